FILE: hw/rtl/dq_pkg.sv
// Shared types, constants and ring index helpers for the double-ended queue.
package dq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
    localparam logic [1:0] MODE_PUSH_BACK  = 2'd1;
    localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
    localparam logic [1:0] MODE_POP_BACK   = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] data_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     pop_was_empty;
        logic                     push_dropped;
        logic [CNT_W-1:0]         occupancy;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } out_item_t;

    typedef struct packed {
        logic load_op;
        logic exec;
        logic peek;
        logic load_out;
    } dq_cmd_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] idx);
        ring_prev = (idx == '0) ? LAST_IDX : idx - 1'b1;
    endfunction

endpackage

FILE: hw/rtl/dq_ctrl.sv
// Sequencing controller for the double-ended queue.
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dq_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_OP   = 2'd1;
    localparam logic [1:0] S_PEEK = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load_op  = (state_reg == S_IDLE) && in_valid;
        cmd.exec     = (state_reg == S_OP);
        cmd.peek     = (state_reg == S_PEEK);
        cmd.load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_OP;
                end
            end
            S_OP:
            begin
                state_next = S_PEEK;
            end
            S_PEEK:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted transaction always runs the execute and peek steps in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_OP))
        else $error("accepted transaction did not start execution");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OP) |=> (state_reg == S_PEEK))
        else $error("execute step not followed by peek step");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result load did not raise valid and release input");

endmodule

FILE: hw/rtl/dq_datapath.sv
// Ring memory, pointers, occupancy count and result register of the queue.
module dq_datapath
    import dq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  dq_cmd_t   cmd,
    output out_item_t out_item
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [1:0]               mode_reg;
    logic [DATA_W-1:0]        data_reg;
    logic [PTR_W-1:0]         front_reg;
    logic [PTR_W-1:0]         front_next;
    logic [PTR_W-1:0]         back_reg;
    logic [PTR_W-1:0]         back_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     was_empty_reg;
    logic                     dropped_reg;
    logic                     pop_ok_reg;
    logic signed [DATA_W-1:0] popped_reg;
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    out_item_t                out_reg;

    logic             is_push;
    logic             full;
    logic             empty;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr_a;
    logic [PTR_W-1:0] rd_addr_b;
    logic             was_empty_next;
    logic             dropped_next;
    logic             pop_ok_next;

    assign is_push   = !mode_reg[1];
    assign full      = (count_reg == FULL_CNT);
    assign empty     = (count_reg == '0);
    assign rd_addr_b = ring_prev(back_reg);

    always_comb
    begin
        front_next     = front_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        wr_addr        = back_reg;
        rd_addr_a      = front_reg;
        was_empty_next = 1'b0;
        dropped_next   = 1'b0;
        pop_ok_next    = 1'b0;
        if (is_push)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                if (mode_reg == MODE_PUSH_FRONT)
                begin
                    front_next = ring_prev(front_reg);
                    wr_addr    = ring_prev(front_reg);
                end
                else
                begin
                    back_next = ring_next(back_reg);
                end
            end
        end
        else
        begin
            if (empty)
            begin
                was_empty_next = 1'b1;
            end
            else
            begin
                pop_ok_next = 1'b1;
                count_next  = count_reg - 1'b1;
                if (mode_reg == MODE_POP_FRONT)
                begin
                    front_next = ring_next(front_reg);
                end
                else
                begin
                    back_next = ring_prev(back_reg);
                    rd_addr_a = ring_prev(back_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= data_reg;
        end
        if (cmd.exec || cmd.peek)
        begin
            rd_a_reg <= mem[cmd.peek ? front_reg : rd_addr_a];
        end
        if (cmd.peek)
        begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            mode_reg <= in_item.mode;
            data_reg <= in_item.data_in;
        end
        if (cmd.exec)
        begin
            was_empty_reg <= was_empty_next;
            dropped_reg   <= dropped_next;
            pop_ok_reg    <= pop_ok_next;
        end
        if (cmd.peek)
        begin
            popped_reg <= pop_ok_reg ? rd_a_reg : '0;
        end
        if (cmd.load_out)
        begin
            out_reg.popped_value  <= popped_reg;
            out_reg.pop_was_empty <= was_empty_reg;
            out_reg.push_dropped  <= dropped_reg;
            out_reg.occupancy     <= count_reg;
            out_reg.is_empty      <= empty;
            out_reg.front_value   <= empty ? '0 : rd_a_reg;
            out_reg.back_value    <= empty ? '0 : rd_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    assign out_item = out_reg;

    // The occupancy never goes past the ring size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("occupancy exceeds ring size");

    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.exec |=> ($stable(count_reg) && $stable(front_reg) && $stable(back_reg)))
        else $error("queue state changed outside the execute step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (dropped_next || was_empty_next)) |=> $stable(count_reg))
        else $error("rejected operation changed the occupancy");

endmodule

FILE: hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: controller and datapath.
//
// Each transaction on the input channel performs one push or pop and yields
// exactly one result transaction. An operation goes through these steps from
// acceptance to the result register: accept the item, update the pointers
// and write or read the ring memory, read the front and back entries from
// the memory's two read ports, and load the result. The input is stalled
// from acceptance until the result is loaded, so a new operation is taken
// only after the previous result is loaded; a stalled output delays that
// load. The ring holds 1024 words and needs no clearing after reset.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    dq_cmd_t cmd;

    dq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    dq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .out_item (out_item)
    );

endmodule

FILE: dv/deque_checker.sv
// Checker that mirrors the double-ended queue and compares each result transaction.
module deque_checker
    import dq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    output int        errors,
    output int        outstanding,
    output int        checked,
    output int        full_pushes,
    output int        empty_pops
);

    logic signed [DATA_W-1:0] ring [DEPTH];
    logic [PTR_W-1:0]         head_slot;
    logic [PTR_W-1:0]         tail_slot;
    logic [CNT_W-1:0]         level;

    out_item_t awaited_results [$];

    int mismatch_count = 0;
    int waiting_count  = 0;
    int checked_count  = 0;
    int refused_count  = 0;
    int underrun_count = 0;

    assign errors      = mismatch_count;
    assign outstanding = waiting_count;
    assign checked     = checked_count;
    assign full_pushes = refused_count;
    assign empty_pops  = underrun_count;

    function automatic logic [PTR_W-1:0] slot_after(input logic [PTR_W-1:0] s);
        return PTR_W'((int'(s) + 1) % DEPTH);
    endfunction

    function automatic logic [PTR_W-1:0] slot_before(input logic [PTR_W-1:0] s);
        return PTR_W'((int'(s) + DEPTH - 1) % DEPTH);
    endfunction

    task automatic apply_deque_op(input in_item_t op, output out_item_t res);
        res = '0;
        case (op.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (level == FULL_CNT)
                begin
                    res.push_dropped = 1'b1;
                    refused_count++;
                end
                else if (op.mode == MODE_PUSH_FRONT)
                begin
                    head_slot = slot_before(head_slot);
                    ring[head_slot] = op.data_in;
                    level = level + 1'b1;
                end
                else
                begin
                    ring[tail_slot] = op.data_in;
                    tail_slot = slot_after(tail_slot);
                    level = level + 1'b1;
                end
            end
            default:
            begin
                if (level == '0)
                begin
                    res.pop_was_empty = 1'b1;
                    underrun_count++;
                end
                else if (op.mode == MODE_POP_FRONT)
                begin
                    res.popped_value = ring[head_slot];
                    head_slot = slot_after(head_slot);
                    level = level - 1'b1;
                end
                else
                begin
                    tail_slot = slot_before(tail_slot);
                    res.popped_value = ring[tail_slot];
                    level = level - 1'b1;
                end
            end
        endcase
        res.occupancy = level;
        res.is_empty  = (level == '0);
        if (level != '0)
        begin
            res.front_value = ring[head_slot];
            res.back_value  = ring[slot_before(tail_slot)];
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t predicted;
        out_item_t oldest;
        if (!rst_n)
        begin
            head_slot = '0;
            tail_slot = '0;
            level     = '0;
            awaited_results.delete();
            waiting_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction arrived with no expected result");
                    mismatch_count++;
                end
                else
                begin
                    oldest = awaited_results[0];
                    awaited_results.delete(0);
                    waiting_count--;
                    checked_count++;
                    check_field("popped_value", oldest.popped_value, out_item.popped_value);
                    check_field("pop_was_empty", oldest.pop_was_empty, out_item.pop_was_empty);
                    check_field("push_dropped", oldest.push_dropped, out_item.push_dropped);
                    check_field("occupancy", oldest.occupancy, out_item.occupancy);
                    check_field("is_empty", oldest.is_empty, out_item.is_empty);
                    check_field("front_value", oldest.front_value, out_item.front_value);
                    check_field("back_value", oldest.back_value, out_item.back_value);
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_deque_op(in_item, predicted);
                awaited_results.insert(awaited_results.size(), predicted);
                waiting_count++;
            end
        end
    end

endmodule

FILE: dv/double_ended_queue_test.sv
// Top of the double-ended queue testbench: clock, reset, stimulus and verdict.
module double_ended_queue_test;
    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_item;

    int errors;
    int outstanding;
    int checked;
    int full_pushes;
    int empty_pops;

    int cycles     = 0;
    int sent       = 0;
    int taken      = 0;
    int fill_level = 0;
    bit send_idle;
    bit take_idle;
    bit hold_request;

    double_ended_queue DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    deque_checker watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .errors     (errors),
        .outstanding(outstanding),
        .checked    (checked),
        .full_pushes(full_pushes),
        .empty_pops (empty_pops)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_op(input logic [1:0] mode, input logic [DATA_W-1:0] data);
        int gap;
        if (sent % 48 == 0)
            send_idle = ($urandom_range(0, 2) != 0);
        gap = send_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= {mode, data};
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        if (mode == MODE_PUSH_FRONT || mode == MODE_PUSH_BACK)
        begin
            if (fill_level < DEPTH)
                fill_level++;
        end
        else if (fill_level > 0)
            fill_level--;
    endtask

    function automatic logic [1:0] any_push();
        return $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
    endfunction

    function automatic logic [1:0] any_pop();
        return $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    initial
    begin
        int hold;
        out_stall = 1'b0;
        take_idle = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end
            else
                hold = take_idle ? $urandom_range(0, 16) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
            if (taken % 40 == 0)
                take_idle = ($urandom_range(0, 2) != 0);
        end
    end

    initial
    begin
        logic [1:0] op;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_item      = '0;
        send_idle    = 1'b1;
        hold_request = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(MODE_POP_FRONT, $urandom);
        send_op(MODE_POP_BACK, $urandom);
        send_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
        send_op(MODE_PUSH_BACK, 32'h8000_0000);
        send_op(MODE_PUSH_FRONT, 32'hffff_ffff);
        send_op(MODE_PUSH_BACK, 32'h0000_0000);
        send_op(MODE_POP_BACK, $urandom);
        send_op(MODE_POP_FRONT, $urandom);
        send_op(MODE_POP_FRONT, $urandom);
        send_op(MODE_POP_BACK, $urandom);
        send_op(MODE_POP_BACK, $urandom);
        send_op(MODE_PUSH_BACK, 32'h5555_5555);
        send_op(MODE_PUSH_BACK, 32'haaaa_aaaa);
        send_op(MODE_POP_FRONT, $urandom);
        send_op(MODE_POP_FRONT, $urandom);
        send_op(MODE_POP_FRONT, $urandom);
        send_op(MODE_PUSH_FRONT, 32'h0000_0001);
        send_op(MODE_POP_BACK, $urandom);

        repeat (80)
        begin
            op = 2'($urandom_range(MODE_PUSH_FRONT, MODE_POP_BACK));
            send_op(op, $urandom);
        end

        // Fill the ring to the top with a long receiver hold at the start.
        hold_request = 1'b1;
        while (fill_level < DEPTH)
        begin
            op = ($urandom_range(0, 99) < 97) ? any_push() : any_pop();
            send_op(op, $urandom);
        end
        repeat (12) send_op(any_push(), $urandom);
        repeat (12)
        begin
            op = 2'($urandom_range(MODE_PUSH_FRONT, MODE_POP_BACK));
            send_op(op, $urandom);
        end
        in_valid <= 1'b0;

        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d operations and checked %0d results, including %0d pushes refused",
                 sent, checked, full_pushes);
        $display("at full occupancy and %0d pops on an empty deque.", empty_pops);
        if (errors == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_ctrl.sv
hw/rtl/dq_datapath.sv
hw/rtl/double_ended_queue.sv
dv/deque_checker.sv
dv/double_ended_queue_test.sv
